// ===== rtl/pps_pkg.sv =====
// Package: shared widths, codes and the table entry type of the priority scheduler.
`timescale 1ns / 1ps
package pps_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int CFG_W     = 5;
  localparam int SLOT_W    = 4;
  localparam int TW        = 16;   // arrival / burst / remaining
  localparam int PW        = 8;    // priority
  localparam int TIME_W    = 24;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [TW-1:0] arrival;
    logic [TW-1:0] burst;
    logic [TW-1:0] remaining;
    logic [PW-1:0] prio;
  } ent_t;

endpackage

// ===== rtl/preemptive_priority_scheduler.sv =====
// Top level: preemptive priority scheduler with a slot table held in one synchronous memory.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | op, slot, arrival, burst, priority_req
//  out     | output    | out_valid / out_ready| ran, ran_slot, finished, finish_time,
//          |           |                      | turnaround, waiting, all_done
//  cfg     | input     | cfg_we (no wait)     | process_count
//
//  Each request runs a scan over n = min(process_count, SLOTS) slots, then the update,
//  turnaround and result steps. The scan reads one slot per cycle from the table
//  memory, whose read is registered.
//  Reset (rst_n, synchronous) clears time, count, the per-slot pending bits and the
//  control; the table memory is not cleared, so reset takes effect at once.
//  A result waits in the output register; the next request is taken meanwhile and
//  only its final step stalls until the previous result is taken.
module preemptive_priority_scheduler #(
  parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [pps_pkg::CFG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [pps_pkg::SLOT_W-1:0]    in_slot,
  input  logic [pps_pkg::TW-1:0]        in_arrival,
  input  logic [pps_pkg::TW-1:0]        in_burst,
  input  logic [pps_pkg::PW-1:0]        in_priority_req,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ran,
  output logic [pps_pkg::SLOT_W-1:0]    out_ran_slot,
  output logic                          out_finished,
  output logic [pps_pkg::TIME_W-1:0]    out_finish_time,
  output logic [pps_pkg::TIME_W-1:0]    out_turnaround,
  output logic [pps_pkg::TIME_W-1:0]    out_waiting,
  output logic                          out_all_done
);
  import pps_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  // wide enough for the process count and for SLOTS itself
  localparam int CW = ($clog2(SLOTS + 1) > CFG_W) ? $clog2(SLOTS + 1) : CFG_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_TAT  = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  count_r;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [SLOTS-1:0]  pend_r, pend_nxt;     // loaded, not done, time left
  logic              chk_v_r, chk_v_nxt;
  logic              out_valid_r, out_valid_nxt;

  // per-request working registers
  logic              op_r, op_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]     pcnt_r, pcnt_nxt;
  logic              found_r, found_nxt;
  ent_t              best_r, best_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic              fin_r, fin_nxt;
  logic [TIME_W-1:0] tat_r, tat_nxt;

  // result register
  logic              ran_r, ran_nxt;
  logic [SLOT_W-1:0] ran_slot_r, ran_slot_nxt;
  logic              finished_r, finished_nxt;
  logic [TIME_W-1:0] finish_time_r, finish_time_nxt;
  logic [TIME_W-1:0] turnaround_r, turnaround_nxt;
  logic [TIME_W-1:0] waiting_r, waiting_nxt;
  logic              all_done_r, all_done_nxt;

  // table memory
  ent_t              mem [SLOTS];
  ent_t              rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  ent_t              mem_wd;

  logic [CW-1:0]     cnt_ext;
  logic              load_ok;
  logic              better;
  logic [TIME_W-1:0] burst_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign rd_addr   = rd_idx_r[IDX_W-1:0];
  assign cnt_ext   = CW'(count_r);
  assign load_ok   = (32'(in_slot) < 32'(SLOTS));
  assign burst_ext = TIME_W'(best_r.burst);

  // lower priority number wins, then earlier arrival; equal keeps the lower slot
  assign better = (rd_data_r.prio < best_r.prio) ||
                  ((rd_data_r.prio == best_r.prio) && (rd_data_r.arrival < best_r.arrival));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt       = state_r;
    time_nxt        = time_r;
    pend_nxt        = pend_r;
    chk_v_nxt       = 1'b0;
    chk_idx_nxt     = rd_addr;
    out_valid_nxt   = out_valid_r & ~out_ready;
    op_nxt          = op_r;
    n_nxt           = n_r;
    rd_idx_nxt      = rd_idx_r;
    pcnt_nxt        = pcnt_r;
    found_nxt       = found_r;
    best_nxt        = best_r;
    best_idx_nxt    = best_idx_r;
    fin_nxt         = fin_r;
    tat_nxt         = tat_r;
    ran_nxt         = ran_r;
    ran_slot_nxt    = ran_slot_r;
    finished_nxt    = finished_r;
    finish_time_nxt = finish_time_r;
    turnaround_nxt  = turnaround_r;
    waiting_nxt     = waiting_r;
    all_done_nxt    = all_done_r;
    mem_we          = 1'b0;
    mem_wa          = best_idx_r;
    mem_wd          = best_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          n_nxt      = (cnt_ext > CW'(SLOTS)) ? CW'(SLOTS) : cnt_ext;
          rd_idx_nxt = '0;
          pcnt_nxt   = '0;
          found_nxt  = 1'b0;
          fin_nxt    = 1'b0;
          state_nxt  = ST_SCAN;
          if (in_op == OP_LOAD && load_ok) begin
            mem_we         = 1'b1;
            mem_wa         = IDX_W'(in_slot);
            mem_wd.arrival   = in_arrival;
            mem_wd.burst     = in_burst;
            mem_wd.remaining = in_burst;
            mem_wd.prio      = in_priority_req;
            pend_nxt[IDX_W'(in_slot)] = (in_burst != '0);
          end
        end
      end
      ST_SCAN: begin
        if (rd_idx_r < n_r) begin
          chk_v_nxt  = 1'b1;
          rd_idx_nxt = rd_idx_r + CW'(1);
        end else begin
          state_nxt = ST_UPD;
        end
        if (chk_v_r && pend_r[chk_idx_r]) begin
          pcnt_nxt = pcnt_r + CW'(1);
          if (op_r == OP_TICK && TIME_W'(rd_data_r.arrival) <= time_r &&
              (!found_r || better)) begin
            found_nxt    = 1'b1;
            best_nxt     = rd_data_r;
            best_idx_nxt = chk_idx_r;
          end
        end
      end
      ST_UPD: begin
        if (op_r == OP_TICK && time_r != TIME_MAX) begin
          time_nxt = time_r + TIME_W'(1);
        end
        if (found_r) begin
          mem_we           = 1'b1;
          mem_wd.remaining = best_r.remaining - TW'(1);
          fin_nxt          = (best_r.remaining == TW'(1));
          if (best_r.remaining == TW'(1)) begin
            pend_nxt[best_idx_r] = 1'b0;
          end
        end
        state_nxt = ST_TAT;
      end
      ST_TAT: begin
        // arrival <= old time, so this never wraps
        tat_nxt   = time_r - TIME_W'(best_r.arrival);
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          ran_nxt         = found_r;
          ran_slot_nxt    = found_r ? SLOT_W'(best_idx_r) : '0;
          finished_nxt    = fin_r;
          finish_time_nxt = fin_r ? time_r : '0;
          turnaround_nxt  = fin_r ? tat_r : '0;
          // waiting clamps at zero once time has saturated
          waiting_nxt     = (fin_r && tat_r >= burst_ext) ? tat_r - burst_ext : '0;
          all_done_nxt    = (pcnt_r == '0) || (pcnt_r == CW'(1) && fin_r);
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      time_r      <= '0;
      pend_r      <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      pend_r      <= pend_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    n_r           <= n_nxt;
    rd_idx_r      <= rd_idx_nxt;
    chk_idx_r     <= chk_idx_nxt;
    pcnt_r        <= pcnt_nxt;
    found_r       <= found_nxt;
    best_r        <= best_nxt;
    best_idx_r    <= best_idx_nxt;
    fin_r         <= fin_nxt;
    tat_r         <= tat_nxt;
    ran_r         <= ran_nxt;
    ran_slot_r    <= ran_slot_nxt;
    finished_r    <= finished_nxt;
    finish_time_r <= finish_time_nxt;
    turnaround_r  <= turnaround_nxt;
    waiting_r     <= waiting_nxt;
    all_done_r    <= all_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ran         = ran_r;
  assign out_ran_slot    = ran_slot_r;
  assign out_finished    = finished_r;
  assign out_finish_time = finish_time_r;
  assign out_turnaround  = turnaround_r;
  assign out_waiting     = waiting_r;
  assign out_all_done    = all_done_r;

  // a completion can only come from a slot that ran
  a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!finished_r || ran_r))
    else $error("finished reported without a slot running");

  // time only moves forward outside reset
  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (time_r >= $past(time_r)))
    else $error("current time went backwards");

  // scan never reads past the counted slots
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_idx_r <= n_r))
    else $error("scan index beyond process count");

  // every accepted request starts a scan
  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN))
    else $error("accepted request did not start a scan");

endmodule

// ===== sim/tb_preemptive_priority_scheduler.sv =====
// Testbench: preemptive priority scheduler, load/tick requests checked against a scheduling model.
`timescale 1ns / 1ps
module tb_preemptive_priority_scheduler;
  import pps_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int TOTAL_REQUESTS = 1950;
  localparam int STALL_LIMIT    = 4000;  // cycles with no handshake on either channel
  localparam int SETTLE_CYCLES  = 8;     // quiet time before a count write
  localparam int DRAIN_CYCLES   = 30;    // longer than one full 16-slot scan
  localparam int HOLD_OFF       = 200;   // long output back-pressure stretch
  localparam int MAX_TICKS      = 60;

  // one result per request
  typedef struct packed {
    logic              ran;
    logic [SLOT_W-1:0] ran_slot;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } sched_result_t;

  // Scheduling model plus in-order result checker.
  class sched_scoreboard;
    logic [CFG_W-1:0]  count;
    logic [TIME_W-1:0] cur_time;
    logic [TW-1:0]     arr_tab[SLOTS_DEF];
    logic [TW-1:0]     burst_tab[SLOTS_DEF];
    logic [TW-1:0]     rem_tab[SLOTS_DEF];
    logic [PW-1:0]     prio_tab[SLOTS_DEF];
    bit                done_tab[SLOTS_DEF];
    sched_result_t     results_due[$];
    int                errors;

    function new();
      count    = '0;
      cur_time = '0;
      errors   = 0;
      foreach (done_tab[i]) begin
        done_tab[i]  = 1'b0;
        arr_tab[i]   = '0;
        burst_tab[i] = '0;
        rem_tab[i]   = '0;
        prio_tab[i]  = '0;
      end
    endfunction

    function void set_count(logic [CFG_W-1:0] value);
      count = value;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function int active_slots();
      return (count > SLOTS_DEF) ? SLOTS_DEF : int'(count);
    endfunction

    function bit all_done_now();
      for (int i = 0; i < active_slots(); i++) begin
        if (!done_tab[i] && rem_tab[i] != 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(logic op, logic [SLOT_W-1:0] slot, logic [TW-1:0] arrival,
                               logic [TW-1:0] burst, logic [PW-1:0] prio);
      sched_result_t     r;
      int                best;
      bit                found;
      logic [TIME_W-1:0] tat;
      r     = '0;
      best  = 0;
      found = 1'b0;
      if (op == OP_LOAD) begin
        arr_tab[slot]   = arrival;
        burst_tab[slot] = burst;
        rem_tab[slot]   = burst;
        prio_tab[slot]  = prio;
        done_tab[slot]  = 1'b0;
      end else begin
        // lowest priority number wins, then earliest arrival, then lowest slot
        for (int i = 0; i < active_slots(); i++) begin
          if (done_tab[i] || rem_tab[i] == 0) continue;
          if (TIME_W'(arr_tab[i]) > cur_time) continue;
          if (!found || prio_tab[i] < prio_tab[best] ||
              (prio_tab[i] == prio_tab[best] && arr_tab[i] < arr_tab[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (cur_time != TIME_MAX) cur_time++;
        if (found) begin
          r.ran      = 1'b1;
          r.ran_slot = SLOT_W'(best);
          rem_tab[best]--;
          if (rem_tab[best] == 0) begin
            done_tab[best] = 1'b1;
            tat            = cur_time - TIME_W'(arr_tab[best]);
            r.finished     = 1'b1;
            r.finish_time  = cur_time;
            r.turnaround   = tat;
            r.waiting      = (tat >= TIME_W'(burst_tab[best])) ?
                             tat - TIME_W'(burst_tab[best]) : '0;
          end
        end
      end
      r.all_done = all_done_now();
      results_due.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp_r;
      if (results_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp_r = results_due.pop_front();
      compare_field("ran",         exp_r.ran,         got.ran);
      compare_field("ran_slot",    exp_r.ran_slot,    got.ran_slot);
      compare_field("finished",    exp_r.finished,    got.finished);
      compare_field("finish_time", exp_r.finish_time, got.finish_time);
      compare_field("turnaround",  exp_r.turnaround,  got.turnaround);
      compare_field("waiting",     exp_r.waiting,     got.waiting);
      compare_field("all_done",    exp_r.all_done,    got.all_done);
    endfunction
  endclass

  // all block inputs start at known values
  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              cfg_we          = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata       = '0;
  logic              in_valid        = 1'b0;
  logic              in_op           = OP_LOAD;
  logic [SLOT_W-1:0] in_slot         = '0;
  logic [TW-1:0]     in_arrival      = '0;
  logic [TW-1:0]     in_burst        = '0;
  logic [PW-1:0]     in_priority_req = '0;
  logic              out_ready       = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ran;
  logic [SLOT_W-1:0] out_ran_slot;
  logic              out_finished;
  logic [TIME_W-1:0] out_finish_time;
  logic [TIME_W-1:0] out_turnaround;
  logic [TIME_W-1:0] out_waiting;
  logic              out_all_done;

  sched_scoreboard sb = new();

  // knobs shared between the stimulus thread and the result sink
  bit sender_gaps_on     = 1'b1;
  bit receiver_stalls_on = 1'b1;
  int hold_off_cycles    = 0;
  int requests_sent      = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  preemptive_priority_scheduler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_slot         (in_slot),
    .in_arrival      (in_arrival),
    .in_burst        (in_burst),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ran         (out_ran),
    .out_ran_slot    (out_ran_slot),
    .out_finished    (out_finished),
    .out_finish_time (out_finish_time),
    .out_turnaround  (out_turnaround),
    .out_waiting     (out_waiting),
    .out_all_done    (out_all_done)
  );

  // Offer one request and return at the edge that accepts it. Valid is left high
  // so a back-to-back request never drops it; a gap lowers it first.
  task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot,
                              input logic [TW-1:0] arrival, input logic [TW-1:0] burst,
                              input logic [PW-1:0] prio);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_slot         <= slot;
    in_arrival      <= arrival;
    in_burst        <= burst;
    in_priority_req <= prio;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(op, slot, arrival, burst, prio);
    requests_sent++;
  endtask

  // Tick: slot and load fields carry junk, the block must ignore them.
  task automatic send_tick();
    send_request(OP_TICK, SLOT_W'($urandom), TW'($urandom), TW'($urandom), PW'($urandom));
  endtask

  // Load with values shaped to make processes arrive soon, finish quickly and tie often,
  // with the odd full-range value mixed in.
  task automatic send_random_load();
    int unsigned a;
    logic [TW-1:0] b;
    logic [PW-1:0] p;
    case ($urandom_range(0, 9))
      0:       a = $urandom_range(0, 16'hFFFF);
      1:       a = 0;
      default: a = sb.cur_time + $urandom_range(0, 12);
    endcase
    if (a > 16'hFFFF) a = 16'hFFFF;
    case ($urandom_range(0, 11))
      0:       b = '0;                              // never runs, counts as done
      1:       b = TW'($urandom_range(1, 16'hFFFF));
      2:       b = '1;
      default: b = TW'($urandom_range(1, 6));
    endcase
    p = ($urandom_range(0, 4) == 0) ? PW'($urandom) : PW'($urandom_range(0, 3));
    send_request(OP_LOAD, SLOT_W'($urandom), TW'(a), b, p);
  endtask

  // Count writes only land with the block drained and the request channel quiet.
  task automatic write_count(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(value);
  endtask

  // Result sink: random ready stalls, plus one long hold-off when asked.
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = receiver_stalls_on ? $urandom_range(0, 5) : 0;
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result('{out_ran, out_ran_slot, out_finished, out_finish_time,
                        out_turnaround, out_waiting, out_all_done});
    end
  end

  // Watchdog: too long without any handshake means the block has hung.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("preemptive_priority_scheduler regression: fail");
    $finish;
  end

  initial begin : stimulus
    int             phase;
    int             ticks;
    int             budget;
    logic [CFG_W-1:0] cnt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Every slot is loaded while the count is still 0, so no scan ever touches an
    // unwritten table entry from here on.
    write_count('0);
    send_request(OP_LOAD, 4'd0,  16'd0,      16'd1,      8'd0);    // shortest, top priority
    send_request(OP_LOAD, 4'd1,  16'hFFFF,   16'hFFFF,   8'hFF);   // never arrives
    send_request(OP_LOAD, 4'd2,  16'd0,      16'd0,      8'd0);    // zero burst
    send_request(OP_LOAD, 4'd3,  16'd0,      16'd2,      8'd5);    // full tie with slot 4
    send_request(OP_LOAD, 4'd4,  16'd0,      16'd2,      8'd5);
    send_request(OP_LOAD, 4'd5,  16'd1,      16'd1,      8'd5);    // same priority, later arrival
    send_request(OP_LOAD, 4'd6,  16'd2,      16'd1,      8'd1);    // arrives and preempts
    for (int s = 7; s < 15; s++)
      send_request(OP_LOAD, SLOT_W'(s), TW'(4 + s), TW'(1 + s % 3), PW'(8'h80 | s));
    send_request(OP_LOAD, 4'd15, 16'd0,      16'd3,      8'd0);    // ties slot 0, loses on slot
    send_tick();                                                  // count 0: idle tick
    write_count(CFG_W'(SLOTS_DEF));
    repeat (6) send_tick();

    // ---- random part ----
    // Each phase: new count, then either noise requests or a few loads and ticks until the
    // counted slots drain or a tick budget runs out, with loads slipped in to force preemption.
    phase = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      case (phase)
        0:       cnt = '1;                          // far beyond the table
        1:       cnt = CFG_W'(1);
        2:       cnt = CFG_W'(SLOTS_DEF + 1);
        default:
          case ($urandom_range(0, 9))
            0:       cnt = '0;
            1:       cnt = CFG_W'(SLOTS_DEF);
            2:       cnt = CFG_W'($urandom_range(SLOTS_DEF + 1, 31));
            default: cnt = CFG_W'($urandom_range(1, SLOTS_DEF));
          endcase
      endcase
      write_count(cnt);
      sender_gaps_on     = ($urandom_range(0, 3) != 0);
      receiver_stalls_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) hold_off_cycles = HOLD_OFF;   // sender keeps offering meanwhile

      if ($urandom_range(0, 7) == 0) begin
        // noise: fully random requests in any order
        repeat (10)
          send_request(logic'($urandom), SLOT_W'($urandom), TW'($urandom),
                       TW'($urandom), PW'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_random_load();
        budget = $urandom_range(8, MAX_TICKS);
        ticks  = 0;
        while (ticks < budget) begin
          if ($urandom_range(0, 7) == 0) begin
            send_random_load();
          end else begin
            send_tick();
            ticks++;
            if (sb.all_done_now()) break;
          end
        end
      end
      phase++;
    end

    // drain: all results in, then a scan's worth of quiet to catch strays
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("preemptive_priority_scheduler regression: pass");
    end else begin
      $display("preemptive_priority_scheduler regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pps_pkg.sv
rtl/preemptive_priority_scheduler.sv
sim/tb_preemptive_priority_scheduler.sv
